// ===== src/decaying_chirp_tone_generator_core_defines.svh =====
`ifndef DECAYING_CHIRP_TONE_GENERATOR_CORE_DEFINES_SVH
`define DECAYING_CHIRP_TONE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low.
`define DCTG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, quiet while rst_n is low.
`define DCTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dctg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dctg_pkg;

  localparam int SINE_ADDR_BITS = 10;
  localparam int COUNT_BITS     = 20;
  localparam int QSIZE          = 1 << SINE_ADDR_BITS;
  localparam int ROM_ADDR_BITS  = SINE_ADDR_BITS + 1;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 31;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] FULL_SCALE  = 64'd32767;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_STEP   = 3'd0,
    REG_STEP_DELTA   = 3'd1,
    REG_START_LEVEL  = 3'd2,
    REG_LEVEL_STEP   = 3'd3,
    REG_SAMPLE_COUNT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [30:0]           start_step;
    logic signed [16:0]    step_delta;
    logic [14:0]           start_level;
    logic [14:0]           level_step;
    logic [COUNT_BITS-1:0] sample_count;
  } cfg_t;

  typedef struct packed {
    logic [ROM_ADDR_BITS-1:0] rom_addr;
    logic                     neg;
    logic [14:0]              level;
    logic                     last;
    logic                     done;
  } issue_t;

  typedef logic [14:0] sine_rom_t [0:QSIZE];

  // Quarter-wave sine, Q30 Horner polynomial, rounded to 15 bits.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int k = 0; k <= QSIZE; k++) begin
      x  = (HALF_PI_Q30 * 64'(k)) >> SINE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s = (x * t) >> 30;
      v = (s * FULL_SCALE + (64'd1 << 29)) >> 30;
      if (v > FULL_SCALE) begin
        v = FULL_SCALE;
      end
      rom[k] = v[14:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ===== src/dctg_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dctg_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  input  wire logic [dctg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [dctg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output dctg_pkg::cfg_t                            cfg_o
);

  dctg_pkg::cfg_t cfg_r;
  dctg_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (dctg_pkg::reg_idx_t'(cfg_index))
        dctg_pkg::REG_START_STEP:   cfg_nxt.start_step   = cfg_data[30:0];
        dctg_pkg::REG_STEP_DELTA:   cfg_nxt.step_delta   = $signed(cfg_data[16:0]);
        dctg_pkg::REG_START_LEVEL:  cfg_nxt.start_level  = cfg_data[14:0];
        dctg_pkg::REG_LEVEL_STEP:   cfg_nxt.level_step   = cfg_data[14:0];
        dctg_pkg::REG_SAMPLE_COUNT:
          cfg_nxt.sample_count = cfg_data[dctg_pkg::COUNT_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// ===== src/dctg_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dctg_sine_rom (
  input  wire logic                                clk,
  input  wire logic                                rd_en,
  input  wire logic [dctg_pkg::ROM_ADDR_BITS-1:0]  rd_addr,
  output logic [14:0]                              rd_data
);

  localparam dctg_pkg::sine_rom_t SineRom = dctg_pkg::build_sine_rom();

  logic [14:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SineRom[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/dctg_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dctg_state (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic        restart,
  input  wire dctg_pkg::cfg_t cfg,
  output dctg_pkg::issue_t issue
);

  localparam int CB = dctg_pkg::COUNT_BITS;
  localparam int AB = dctg_pkg::SINE_ADDR_BITS;
  localparam int RB = dctg_pkg::ROM_ADDR_BITS;

  logic [31:0]    phase_r, phase_nxt;
  logic [30:0]    step_r, step_nxt;
  logic [14:0]    level_r, level_nxt;
  logic [CB-1:0]  index_r, index_nxt;

  logic [31:0]        ph;
  logic [30:0]        st;
  logic [14:0]        lv;
  logic [CB-1:0]      ix;
  logic [CB-1:0]      ix_inc;
  logic               done;
  logic signed [32:0] step_sum;
  logic [AB-1:0]      addr;

  always_comb begin
    ph     = restart ? 32'd0 : phase_r;
    st     = restart ? cfg.start_step : step_r;
    lv     = restart ? cfg.start_level : level_r;
    ix     = restart ? '0 : index_r;
    ix_inc = ix + CB'(1);
    done   = (ix >= cfg.sample_count);

    step_sum = $signed({2'b00, st}) + 33'(cfg.step_delta);

    phase_nxt = ph;
    step_nxt  = st;
    level_nxt = lv;
    index_nxt = ix;
    if (!done) begin
      phase_nxt = ph + {1'b0, st};
      if (step_sum[32]) begin
        step_nxt = '0;
      end else if (step_sum[31]) begin
        step_nxt = '1;
      end else begin
        step_nxt = step_sum[30:0];
      end
      level_nxt = (lv >= cfg.level_step) ? lv - cfg.level_step : 15'd0;
      index_nxt = ix_inc;
    end

    addr           = ph[29 -: AB];
    issue.rom_addr = ph[30] ? RB'(dctg_pkg::QSIZE) - {1'b0, addr} : {1'b0, addr};
    issue.neg      = ph[31];
    issue.level    = lv;
    issue.done     = done;
    issue.last     = !done && (ix_inc == cfg.sample_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= '0;
      level_r <= '0;
      index_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      level_r <= level_nxt;
      index_r <= index_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/decaying_chirp_tone_generator_core.sv =====
// Linear chirp tone generator with linear amplitude decay. Each input beat
// (restart flag in in_tdata[0]) yields one output beat: a signed 16-bit PCM
// sample in out_tdata, out_tlast on the final sample of the sound, and
// out_tuser set once the sample count is used up (sample then reads zero).
// One beat is taken every cycle unless both stages are full and out_tready
// is low; a result passes the registered quarter-wave sine ROM read and the
// output register. Phase, increment, level and index update at input accept,
// so back-to-back beats need no interlock. cfg_ready is always high. Registers
// are to be written through cfg_* only while the block is idle; the block does
// not enforce it. start_step and start_level take effect at the next restart.
`timescale 1ns / 1ps
`default_nettype none

`include "decaying_chirp_tone_generator_core_defines.svh"

module decaying_chirp_tone_generator_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [0] restart
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [15:0]                              out_tdata,  // [15:0] sample
  output logic                                     out_tlast,
  output logic                                     out_tuser,  // [0] done_res
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dctg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [dctg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  dctg_pkg::cfg_t   cfg;
  dctg_pkg::issue_t issue;

  logic        in_acc;
  logic        s1_adv;
  logic [14:0] mag;

  logic        s1_v_r, s1_v_nxt;
  logic        s1_neg_r;
  logic        s1_last_r;
  logic        s1_done_r;
  logic [14:0] s1_level_r;

  logic        out_v_r, out_v_nxt;
  logic [15:0] out_data_r;
  logic        out_last_r;
  logic        out_done_r;

  logic [29:0] prod;
  logic [15:0] mag_s;
  logic [15:0] sample;

  assign cfg_ready = 1'b1;

  dctg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  dctg_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .restart (in_tdata[0]),
    .cfg     (cfg),
    .issue   (issue)
  );

  dctg_sine_rom u_rom (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (issue.rom_addr),
    .rd_data (mag)
  );

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || !out_v_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    prod   = mag * s1_level_r;
    mag_s  = {1'b0, prod[29:15]};
    if (s1_done_r) begin
      sample = 16'd0;
    end else if (s1_neg_r) begin
      sample = 16'd0 - mag_s;
    end else begin
      sample = mag_s;
    end

    s1_v_nxt = in_acc || (s1_v_r && !s1_adv);
    out_v_nxt = s1_adv || (out_v_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
    if (in_acc) begin
      s1_neg_r   <= issue.neg;
      s1_last_r  <= issue.last;
      s1_done_r  <= issue.done;
      s1_level_r <= issue.level;
    end
    if (s1_adv) begin
      out_data_r <= sample;
      out_last_r <= s1_last_r;
      out_done_r <= s1_done_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  `DCTG_ASSERT_NOW(a_done_zero, out_tvalid && out_tuser, (out_tdata == 16'd0) && !out_tlast,
    "done beat carries nonzero sample or last")
  `DCTG_ASSERT_NOW(a_full_stall, s1_v_r && out_v_r && !out_tready, !in_tready,
    "input taken while both stages are full and stalled")
  `DCTG_ASSERT_NEXT(a_accept_fills, in_acc, s1_v_r,
    "accepted beat did not reach the ROM stage")

endmodule

`default_nettype wire
